// ----- rtl/core/cwrg_pkg.sv -----
// Shared types, constants and tables for the calendar week row generator.
package cwrg_pkg;

   localparam int YearW   = 15;
   localparam int MonthW  = 4;
   localparam int RowW    = 3;
   localparam int ColW    = 3;
   localparam int DayW    = 5;
   localparam int DomW    = 6;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 15;

   localparam int QueueDepthDefault = 4;

   // reciprocal multipliers, both round down so one correction step suffices
   localparam int Div25Mul   = 1310;   // floor(2^15 / 25)
   localparam int Div25Shift = 15;
   localparam int Div7Mul    = 37449;  // floor(2^18 / 7)
   localparam int Div7Shift  = 18;

   localparam logic [YearW-1:0]  GregYear    = YearW'(1752);
   localparam logic [MonthW-1:0] TransMonth  = MonthW'(8);
   localparam logic [MonthW-1:0] LastMonth   = MonthW'(11);
   localparam logic [MonthW-1:0] FebMonth    = MonthW'(1);
   localparam logic [DomW-1:0]   TransSkip   = DomW'(11);
   localparam logic [DomW-1:0]   TransLastOld = DomW'(2);
   localparam logic [DomW-1:0]   TransFirstNew = DomW'(14);
   localparam logic [2:0]        SpecialWeekday = 3'd3;
   localparam logic [DayW-1:0]   LeapFebLen  = DayW'(29);
   localparam logic [RowW-1:0]   FirstRow    = RowW'(1);
   localparam logic [RowW-1:0]   LastRow     = RowW'(6);
   localparam logic [ColW-1:0]   LastCol     = ColW'(6);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FIRST_WEEKDAY = 2'd0,
      CSR_TODAY_YEAR    = 2'd1,
      CSR_TODAY_MONTH   = 2'd2,
      CSR_TODAY_DAY     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [2:0]        first_weekday;
      logic [YearW-1:0]  today_year;
      logic [MonthW-1:0] today_month;
      logic [DayW-1:0]   today_day;
   } cfg_type;

   // one decoded row, handed from the front to the cell emitter
   typedef struct packed {
      logic              blank;
      logic [ColW-1:0]   start_col;
      logic [DomW-1:0]   dom;
      logic [DayW-1:0]   len;
      logic              trans;
      logic              match;
   } cell_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month);
      logic [DayW-1:0] len;
      case (month)
         4'd1:                      len = DayW'(28);
         4'd3, 4'd5, 4'd8, 4'd10:   len = DayW'(30);
         default:                   len = DayW'(31);
      endcase
      return len;
   endfunction

   // (31 * m) / 12 with m the March-based month index
   function automatic logic [DayW-1:0] month_shift(input logic [MonthW-1:0] month);
      logic [DayW-1:0] s;
      case (month)
         4'd0:    s = DayW'(28);
         4'd1:    s = DayW'(31);
         4'd2:    s = DayW'(2);
         4'd3:    s = DayW'(5);
         4'd4:    s = DayW'(7);
         4'd5:    s = DayW'(10);
         4'd6:    s = DayW'(12);
         4'd7:    s = DayW'(15);
         4'd8:    s = DayW'(18);
         4'd9:    s = DayW'(20);
         4'd10:   s = DayW'(23);
         4'd11:   s = DayW'(25);
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/core/cwrg_if.sv -----
// Channel interfaces: row requests, cell results and register writes.
interface cwrg_req_if;
   logic                           valid;
   logic                           ready;
   logic [cwrg_pkg::YearW-1:0]     year;
   logic [cwrg_pkg::MonthW-1:0]    month;
   logic [cwrg_pkg::RowW-1:0]      row;
   modport source (output valid, year, month, row, input ready);
   modport sink   (input valid, year, month, row, output ready);
endinterface

interface cwrg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cwrg_pkg::ColW-1:0]      column;
   logic [cwrg_pkg::DayW-1:0]      day;
   logic                           highlight;
   logic                           last;
   modport source (output valid, column, day, highlight, last, input ready);
   modport sink   (input valid, column, day, highlight, last, output ready);
endinterface

interface cwrg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [cwrg_pkg::CsrIdxW-1:0]   index;
   logic [cwrg_pkg::CsrDataW-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cwrg_front.sv -----
// Front pipeline: decodes a row request into a cell job (weekday of the first, month length).
module cwrg_front (
   input  logic                       clock,
   input  logic                       reset,
   cwrg_req_if.sink                   req,
   input  cwrg_pkg::cfg_type          cfg,
   input  cwrg_pkg::queue_status_type q_stat,
   output logic                       push,
   output cwrg_pkg::cell_job_type     push_job
);

   typedef struct packed {
      logic [cwrg_pkg::YearW-1:0] year;
      logic [cwrg_pkg::RowW-1:0]  row;
      logic                       ok;
      logic                       greg;
      logic                       trans;
      logic                       is_feb;
      logic                       match;
      logic signed [15:0]         y;
      logic [12:0]                y4;
      logic [12:0]                yr4;
      logic [cwrg_pkg::DayW-1:0]  shift;
      logic [cwrg_pkg::DayW-1:0]  len;
      logic [23:0]                prod_y;
      logic [23:0]                prod_r;
      logic [8:0]                 q100;
      logic [15:0]                sum;
      logic [31:0]                prod7;
      logic [2:0]                 wd;
   } pipe_type;

   localparam int Stages = 6;

   logic                  adv;
   logic [Stages-1:0]     vld_ff, vld_in;
   pipe_type              st_ff [Stages];
   pipe_type              st_in [Stages];

   assign adv       = !q_stat.full;
   assign req.ready = adv;

   // stage 1: capture and classify
   always_comb begin
      logic a;
      st_in[0]        = st_ff[0];
      a               = (req.month == 4'd0) || (req.month == cwrg_pkg::FebMonth);
      st_in[0].year   = req.year;
      st_in[0].row    = req.row;
      st_in[0].ok     = (req.month <= cwrg_pkg::LastMonth) &&
                        (req.row >= cwrg_pkg::FirstRow) && (req.row <= cwrg_pkg::LastRow);
      st_in[0].greg   = !((req.year < cwrg_pkg::GregYear) ||
                          ((req.year == cwrg_pkg::GregYear) &&
                           (req.month <= cwrg_pkg::TransMonth)));
      st_in[0].trans  = (req.year == cwrg_pkg::GregYear) &&
                        (req.month == cwrg_pkg::TransMonth);
      st_in[0].is_feb = (req.month == cwrg_pkg::FebMonth);
      st_in[0].match  = (cfg.today_day != '0) && (req.year == cfg.today_year) &&
                        (req.month == cfg.today_month);
      st_in[0].y      = a ? ($signed({1'b0, req.year}) - 16'sd1) : $signed({1'b0, req.year});
      st_in[0].y4     = st_in[0].y[15] ? 13'd0 : st_in[0].y[14:2];
      st_in[0].yr4    = req.year[14:2];
      st_in[0].shift  = cwrg_pkg::month_shift(req.month);
      st_in[0].len    = cwrg_pkg::month_len(req.month);
   end

   // stage 2: reciprocal products for the divisions by 25
   always_comb begin
      st_in[1]        = st_ff[0];
      st_in[1].prod_y = 24'(st_ff[0].y4) * 24'(cwrg_pkg::Div25Mul);
      st_in[1].prod_r = 24'(st_ff[0].yr4) * 24'(cwrg_pkg::Div25Mul);
   end

   // stage 3: correct the quotients, leap rule, month length
   always_comb begin
      logic [8:0]  q0y, q0r, q100r;
      logic [13:0] ry, rr, rem_r;
      logic        div4, c100, c400, leap;
      st_in[2] = st_ff[1];
      q0y      = st_ff[1].prod_y[cwrg_pkg::Div25Shift +: 9];
      q0r      = st_ff[1].prod_r[cwrg_pkg::Div25Shift +: 9];
      ry       = {1'b0, st_ff[1].y4} - 14'(q0y) * 14'd25;
      rr       = {1'b0, st_ff[1].yr4} - 14'(q0r) * 14'd25;
      st_in[2].q100 = (ry >= 14'd25) ? q0y + 9'd1 : q0y;
      q100r    = (rr >= 14'd25) ? q0r + 9'd1 : q0r;
      rem_r    = (rr >= 14'd25) ? rr - 14'd25 : rr;
      div4     = (st_ff[1].year[1:0] == 2'd0);
      c100     = div4 && (rem_r == 14'd0);
      c400     = c100 && (q100r[1:0] == 2'd0);
      leap     = st_ff[1].greg ? (c400 || (div4 && !c100)) : div4;
      st_in[2].len = (st_ff[1].is_feb && leap) ? cwrg_pkg::LeapFebLen : st_ff[1].len;
   end

   // stage 4: day-count sum ahead of the mod 7
   always_comb begin
      logic [16:0] s;
      st_in[3] = st_ff[2];
      s = {st_ff[2].y[15], st_ff[2].y} + {4'b0, st_ff[2].y4} + {12'b0, st_ff[2].shift} +
          (st_ff[2].greg ? (17'd1 - {8'b0, st_ff[2].q100} + {10'b0, st_ff[2].q100[8:2]})
                         : 17'd6);
      st_in[3].sum = s[15:0];
   end

   // stage 5: reciprocal product for the mod 7
   always_comb begin
      st_in[4]       = st_ff[3];
      st_in[4].prod7 = 32'(st_ff[3].sum) * 32'(cwrg_pkg::Div7Mul);
   end

   // stage 6: weekday of the first of the month
   always_comb begin
      logic [13:0] q7;
      logic [15:0] r7;
      st_in[5]    = st_ff[4];
      q7          = st_ff[4].prod7[cwrg_pkg::Div7Shift +: 14];
      r7          = st_ff[4].sum - 16'(q7) * 16'd7;
      st_in[5].wd = (r7 >= 16'd7) ? 3'(r7 - 16'd7) : 3'(r7);
   end

   always_comb begin
      vld_in = {vld_ff[Stages-2:0], req.valid && adv};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         for (int i = 0; i < Stages; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // job for the cell emitter
   always_comb begin
      logic [3:0]                 off;
      logic [2:0]                 offset;
      logic [cwrg_pkg::DomW-1:0]  dom;
      pipe_type                   s;
      s      = st_ff[Stages-1];
      off    = {1'b0, s.wd} - {1'b0, cfg.first_weekday};
      offset = off[3] ? 3'(off + 4'd7) : off[2:0];
      dom    = cwrg_pkg::DomW'(8) - cwrg_pkg::DomW'(offset) +
               (cwrg_pkg::DomW'(s.row) - cwrg_pkg::DomW'(2)) * cwrg_pkg::DomW'(7);
      // rows past the skip start later, except the row that still holds day 2
      if (s.trans && !((s.row == 3'd2) && (cfg.first_weekday == cwrg_pkg::SpecialWeekday))) begin
         dom = dom + cwrg_pkg::TransSkip;
      end
      push_job.blank = !s.ok;
      push_job.len   = s.len;
      push_job.trans = s.trans;
      push_job.match = s.match;
      if (s.row == cwrg_pkg::FirstRow) begin
         push_job.start_col = offset;
         push_job.dom       = cwrg_pkg::DomW'(1);
      end else begin
         push_job.start_col = '0;
         push_job.dom       = dom;
      end
   end

   assign push = adv && vld_ff[Stages-1];

endmodule

// ----- rtl/core/cwrg_queue.sv -----
// Small job queue between the decode front and the cell emitter.
module cwrg_queue #(
   parameter int Depth = cwrg_pkg::QueueDepthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cwrg_pkg::cell_job_type      push_job,
   input  logic                        pop,
   output cwrg_pkg::cell_job_type      head_job,
   output cwrg_pkg::queue_status_type  stat
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   cwrg_pkg::cell_job_type mem_ff [Depth];
   logic [PtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]        count_ff, count_in;

   assign stat.full  = (count_ff == CntW'(Depth));
   assign stat.empty = (count_ff == '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/cwrg_back.sv -----
// Cell emitter: walks one job across the seven columns into the result register.
module cwrg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cwrg_pkg::cfg_type           cfg,
   input  cwrg_pkg::cell_job_type      head_job,
   input  cwrg_pkg::queue_status_type  q_stat,
   output logic                        pop,
   cwrg_rsp_if.source                  rsp
);

   logic                          cur_valid_ff, cur_valid_in;
   cwrg_pkg::cell_job_type        job_ff, job_in;
   logic [cwrg_pkg::ColW-1:0]     col_ff, col_in;
   logic [cwrg_pkg::DomW-1:0]     dom_ff, dom_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cwrg_pkg::ColW-1:0]     column_ff;
   logic [cwrg_pkg::DayW-1:0]     day_ff, day_in;
   logic                          highlight_ff, highlight_in;
   logic                          last_ff;

   logic out_free, emit, done, active;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = cur_valid_ff && out_free;
   assign done     = emit && (col_ff == cwrg_pkg::LastCol);
   assign pop      = !q_stat.empty && (!cur_valid_ff || done);
   assign active   = !job_ff.blank && (col_ff >= job_ff.start_col);

   always_comb begin
      day_in = '0;
      if (active && (dom_ff <= cwrg_pkg::DomW'(job_ff.len))) begin
         day_in = dom_ff[cwrg_pkg::DayW-1:0];
      end
      highlight_in = (day_in != '0) && job_ff.match && (day_in == cfg.today_day);
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      job_in       = job_ff;
      col_in       = col_ff;
      dom_in       = dom_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         job_in       = head_job;
         col_in       = '0;
         dom_in       = head_job.dom;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         col_in = col_ff + cwrg_pkg::ColW'(1);
         if (active) begin
            // the transition month skips from day 2 straight to 14
            dom_in = (job_ff.trans && (dom_ff == cwrg_pkg::TransLastOld)) ?
                     cwrg_pkg::TransFirstNew : dom_ff + cwrg_pkg::DomW'(1);
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      col_ff <= col_in;
      dom_ff <= dom_in;
      if (emit) begin
         column_ff    <= col_ff;
         day_ff       <= day_in;
         highlight_ff <= highlight_in;
         last_ff      <= (col_ff == cwrg_pkg::LastCol);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.column    = column_ff;
   assign rsp.day       = day_ff;
   assign rsp.highlight = highlight_ff;
   assign rsp.last      = last_ff;

endmodule

// ----- rtl/core/calendar_week_row_generator.sv -----
// Top level of the calendar week row generator: registers, front, queue and emitter.
//
// A request on req_bus carries year, zero-based month and week row 1..6. For each
// accepted request the block returns seven results on rsp_bus, columns 0 to 6 in order,
// each with the day of month (0 for a blank cell), a highlight bit for the configured
// today date, and last set on column 6. Month 12..15 or row 0 or 7 gives seven blanks.
// Registers are written on csr_bus (0 first_weekday, 1 today_year, 2 today_month,
// 3 today_day); csr_bus is always ready and writes are meant for an idle block.
// A row's first cell passes the six-stage decode pipeline (divisions by 25 and 7 via
// reciprocal products), the queue, the emitter's job register and the result register.
// Cells go out one per cycle while rsp_bus is ready, set by the single result channel.
// Requests are taken back to back while the job queue has room; req_bus.ready drops
// only when full. A stall on rsp_bus holds the current cell in the result register;
// the emitter waits, the queue fills, and then the decode pipeline holds as a whole.
// Reset (synchronous, active high) clears the configuration registers, the queue and
// every valid flag, and drops every request in flight.
module calendar_week_row_generator #(
   parameter int QueueDepth = cwrg_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   cwrg_req_if.sink   req_bus,
   cwrg_rsp_if.source rsp_bus,
   cwrg_csr_if.sink   csr_bus
);

   cwrg_pkg::cfg_type           cfg_ff, cfg_in;
   cwrg_pkg::cell_job_type      q_push_job, q_head_job;
   cwrg_pkg::queue_status_type  q_stat;
   logic                        q_push, q_pop;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (cwrg_pkg::csr_index_type'(csr_bus.index))
            cwrg_pkg::CSR_FIRST_WEEKDAY: cfg_in.first_weekday = csr_bus.data[2:0];
            cwrg_pkg::CSR_TODAY_YEAR:    cfg_in.today_year    = csr_bus.data[14:0];
            cwrg_pkg::CSR_TODAY_MONTH:   cfg_in.today_month   = csr_bus.data[3:0];
            cwrg_pkg::CSR_TODAY_DAY:     cfg_in.today_day     = csr_bus.data[4:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cwrg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .push     (q_push),
      .push_job (q_push_job)
   );

   cwrg_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .stat     (q_stat)
   );

   cwrg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_job (q_head_job),
      .q_stat   (q_stat),
      .pop      (q_pop),
      .rsp      (rsp_bus)
   );

   // a row's cells go out without gaps once the first one is taken
   a_row_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=> rsp_bus.valid)
      else $error("gap inside a row of cells");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("job queue written while full");

   a_highlight_today: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.highlight |->
         (rsp_bus.day == cfg_ff.today_day) && (rsp_bus.day != '0))
      else $error("highlight on a cell that is not today");

endmodule

// ----- test/calendar_cell_checker.sv -----
// Checker for the calendar week row generator: predicts each row's cells and compares results.
module calendar_cell_checker (
   input  logic       clock,
   input  logic       reset,
   cwrg_req_if        req_bus,
   cwrg_rsp_if        rsp_bus,
   cwrg_csr_if        csr_bus,
   output int         fail_count,
   output int         cells_due,
   output int         cells_checked,
   output int         highlights_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [cwrg_pkg::ColW-1:0] column;
      logic [cwrg_pkg::DayW-1:0] day;
      logic                      highlight;
      logic                      last;
   } cal_cell_type;

   // register copies, updated on the same writes the block sees
   logic [2:0]                  first_weekday;
   logic [cwrg_pkg::YearW-1:0]  today_year;
   logic [cwrg_pkg::MonthW-1:0] today_month;
   logic [cwrg_pkg::DayW-1:0]   today_day;

   cal_cell_type due_cells[$];
   cal_cell_type want;
   int           errors = 0;
   int           checked = 0;
   int           lit = 0;

   function automatic int month_length(input int yr, input int mo, input bit greg);
      bit leap;
      leap = (yr % 4 == 0);
      if (greg && yr % 100 == 0) leap = (yr % 400 == 0);
      case (mo)
         1:           return leap ? 29 : 28;
         3, 5, 8, 10: return 30;
         default:     return 31;
      endcase
   endfunction

   // queue the seven cells of one week row
   function automatic void lay_out_row(input logic [cwrg_pkg::YearW-1:0] year,
                                       input logic [cwrg_pkg::MonthW-1:0] month,
                                       input logic [cwrg_pkg::RowW-1:0] row);
      int                        yr, mo, rw, fday, a, y, m, wd, offset, len, dom, col;
      bit                        greg, trans;
      logic [cwrg_pkg::DayW-1:0] days [7];
      cal_cell_type              entry;
      yr   = int'(year);
      mo   = int'(month);
      rw   = int'(row);
      fday = int'(first_weekday);
      for (col = 0; col < 7; col++) days[col] = '0;
      if (mo <= 11 && rw >= 1 && rw <= 6) begin
         greg  = !(yr < cwrg_pkg::GregYear ||
                   (yr == cwrg_pkg::GregYear && mo <= cwrg_pkg::TransMonth));
         trans = (yr == cwrg_pkg::GregYear && mo == cwrg_pkg::TransMonth);
         // January and February count as months 11 and 12 of the year before
         a = (13 - mo) / 12;
         y = yr - a;
         m = mo + 12 * a - 1;
         if (greg) wd = (1 + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
         else      wd = (6 + y + y / 4 + (31 * m) / 12) % 7;
         offset = wd - fday;
         if (offset < 0) offset += 7;
         len = month_length(yr, mo, greg);
         col = 0;
         if (rw == 1) begin
            col = offset;
            dom = 1;
         end else begin
            dom = 8 - offset + (rw - 2) * 7;
            // rows past the skip start 11 days on, except the row holding day 2
            if (trans && !(rw == 2 && fday == cwrg_pkg::SpecialWeekday)) dom += 11;
         end
         while (col < 7 && dom <= len) begin
            days[col] = cwrg_pkg::DayW'(dom);
            if (trans && dom == cwrg_pkg::TransLastOld) dom += 11;
            col++;
            dom++;
         end
      end
      for (col = 0; col < 7; col++) begin
         entry.column    = cwrg_pkg::ColW'(col);
         entry.day       = days[col];
         entry.highlight = days[col] != '0 && today_day != '0 && year == today_year &&
                           month == today_month && days[col] == today_day;
         entry.last      = (col == 6);
         due_cells.push_back(entry);
      end
   endfunction

   function automatic void compare_field(input string name,
                                         input logic [cwrg_pkg::DayW-1:0] expected,
                                         input logic [cwrg_pkg::DayW-1:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         due_cells.delete();
         first_weekday = '0;
         today_year    = '0;
         today_month   = '0;
         today_day     = '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (cwrg_pkg::csr_index_type'(csr_bus.index))
               cwrg_pkg::CSR_FIRST_WEEKDAY: first_weekday = csr_bus.data[2:0];
               cwrg_pkg::CSR_TODAY_YEAR:    today_year    = csr_bus.data[cwrg_pkg::YearW-1:0];
               cwrg_pkg::CSR_TODAY_MONTH:   today_month   = csr_bus.data[cwrg_pkg::MonthW-1:0];
               cwrg_pkg::CSR_TODAY_DAY:     today_day     = csr_bus.data[cwrg_pkg::DayW-1:0];
               default: ;
            endcase
         end
         // results first, so a cell arriving too early never matches this edge's request
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_cells.size() == 0) begin
               $error("cell with no request pending: column %0d, day %0d",
                      rsp_bus.column, rsp_bus.day);
               errors++;
            end else begin
               want = due_cells.pop_front();
               compare_field("column", cwrg_pkg::DayW'(want.column),
                             cwrg_pkg::DayW'(rsp_bus.column));
               compare_field("day", want.day, rsp_bus.day);
               compare_field("highlight", cwrg_pkg::DayW'(want.highlight),
                             cwrg_pkg::DayW'(rsp_bus.highlight));
               compare_field("last", cwrg_pkg::DayW'(want.last),
                             cwrg_pkg::DayW'(rsp_bus.last));
               checked++;
               if (want.highlight) lit++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            lay_out_row(req_bus.year, req_bus.month, req_bus.row);
         end
      end
      fail_count         <= errors;
      cells_due          <= due_cells.size();
      cells_checked      <= checked;
      highlights_checked <= lit;
   end

endmodule

// ----- test/calendar_week_row_generator_tb.sv -----
// Testbench top for the calendar week row generator: stimulus, pacing and verdict.
module calendar_week_row_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_mode_type;

   logic clock = 1'b0;
   logic reset;

   cwrg_req_if req_bus ();
   cwrg_rsp_if rsp_bus ();
   cwrg_csr_if csr_bus ();

   int fail_count;
   int cells_due;
   int cells_checked;
   int highlights_checked;

   int                          req_gap_pct = 0;
   int                          rsp_stall_pct = 0;
   int                          rows_sent = 0;
   int                          directed_rows = 0;
   int                          settings_used = 0;
   logic [cwrg_pkg::YearW-1:0]  set_year;
   logic [cwrg_pkg::MonthW-1:0] set_month;

   calendar_week_row_generator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   calendar_cell_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_bus            (req_bus),
      .rsp_bus            (rsp_bus),
      .csr_bus            (csr_bus),
      .fail_count         (fail_count),
      .cells_due          (cells_due),
      .cells_checked      (cells_checked),
      .highlights_checked (highlights_checked)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic set_pace(input pace_mode_type mode);
      case (mode)
         PACE_FREE:     begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
         PACE_SENDER:   begin req_gap_pct = 48; rsp_stall_pct = 0;  end
         PACE_RECEIVER: begin req_gap_pct = 0;  rsp_stall_pct = 48; end
         default:       begin req_gap_pct = 6;  rsp_stall_pct = 6;  end
      endcase
   endtask

   // entered at a rising edge; returns at the edge where the request is taken
   task automatic send_row(input logic [cwrg_pkg::YearW-1:0] y,
                           input logic [cwrg_pkg::MonthW-1:0] m,
                           input logic [cwrg_pkg::RowW-1:0] r);
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.year  <= y;
      req_bus.month <= m;
      req_bus.row   <= r;
      do @(posedge clock); while (!req_bus.ready);
      rows_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (cells_due != 0);
   endtask

   task automatic csr_write(input cwrg_pkg::csr_index_type idx,
                            input logic [cwrg_pkg::CsrDataW-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // only called with the block idle
   task automatic load_settings(input logic [2:0] fw, input logic [cwrg_pkg::YearW-1:0] ty,
                                input logic [cwrg_pkg::MonthW-1:0] tm,
                                input logic [cwrg_pkg::DayW-1:0] td);
      csr_write(cwrg_pkg::CSR_FIRST_WEEKDAY, cwrg_pkg::CsrDataW'(fw));
      csr_write(cwrg_pkg::CSR_TODAY_YEAR, cwrg_pkg::CsrDataW'(ty));
      csr_write(cwrg_pkg::CSR_TODAY_MONTH, cwrg_pkg::CsrDataW'(tm));
      csr_write(cwrg_pkg::CSR_TODAY_DAY, cwrg_pkg::CsrDataW'(td));
      csr_bus.valid <= 1'b0;
      set_year  = ty;
      set_month = tm;
      settings_used++;
   endtask

   // mostly real months near the highlighted date and the 1752 switch, some noise
   task automatic send_random_row();
      int                          pick;
      logic [cwrg_pkg::YearW-1:0]  y;
      logic [cwrg_pkg::MonthW-1:0] m;
      logic [cwrg_pkg::RowW-1:0]   r;
      pick = $urandom_range(99);
      r = cwrg_pkg::RowW'($urandom_range(6, 1));
      m = cwrg_pkg::MonthW'($urandom_range(11));
      y = cwrg_pkg::YearW'($urandom);
      if (pick < 35) begin
         y = set_year;
         m = set_month;
      end else if (pick < 55) begin
         y = cwrg_pkg::YearW'($urandom_range(1754, 1750));
         if ($urandom_range(1)) m = cwrg_pkg::TransMonth;
      end else if (pick < 70) begin
         y = cwrg_pkg::YearW'($urandom);
      end else if (pick < 80) begin
         y = $urandom_range(1) ? cwrg_pkg::YearW'($urandom_range(3))
                               : cwrg_pkg::YearW'($urandom_range(32767, 32764));
      end else if (pick < 90) begin
         y = cwrg_pkg::YearW'(100 * $urandom_range(327));
         m = cwrg_pkg::MonthW'($urandom_range(2));
      end else begin
         m = cwrg_pkg::MonthW'($urandom);
         r = cwrg_pkg::RowW'($urandom);
      end
      send_row(y, m, r);
   endtask

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.year  <= '0;
      req_bus.month <= '0;
      req_bus.row   <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= cwrg_pkg::CSR_FIRST_WEEKDAY;
      csr_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // September 1752 with the weekday-3 layout, and its neighbors
      set_pace(PACE_FREE);
      load_settings(3'd3, 15'd1752, 4'd8, 5'd14);
      for (int r = 1; r <= 6; r++) send_row(15'd1752, cwrg_pkg::TransMonth, cwrg_pkg::RowW'(r));
      send_row(15'd1752, 4'd7, 3'd5);
      send_row(15'd1752, 4'd9, 3'd1);
      wait_drained();

      // year zero, out-of-range fields, leap rules; weekday 7
      set_pace(PACE_SENDER);
      load_settings(3'd7, 15'd0, 4'd0, 5'd1);
      send_row(15'd0, 4'd0, 3'd1);
      send_row(15'd0, 4'd0, 3'd2);
      send_row(15'd0, 4'd1, 3'd5);
      send_row(15'd0, 4'd1, 3'd1);
      send_row(15'd2000, 4'd12, 3'd3);
      send_row(15'd2000, 4'd15, 3'd3);
      send_row(15'd2000, 4'd3, 3'd0);
      send_row(15'd2000, 4'd3, 3'd7);
      send_row(15'd2000, cwrg_pkg::FebMonth, 3'd5);
      send_row(15'd1900, cwrg_pkg::FebMonth, 3'd5);
      wait_drained();

      set_pace(PACE_RECEIVER);
      load_settings(3'd6, 15'd32767, cwrg_pkg::LastMonth, 5'd31);
      send_row(15'd32767, cwrg_pkg::LastMonth, 3'd5);
      send_row(15'd32767, cwrg_pkg::LastMonth, 3'd6);
      send_row(15'd1700, cwrg_pkg::FebMonth, 3'd5);
      send_row(15'd1752, cwrg_pkg::TransMonth, 3'd2);
      send_row(15'd1752, cwrg_pkg::TransMonth, 3'd3);
      wait_drained();
      directed_rows = rows_sent;

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: load_settings(3'd0, 15'd2024, cwrg_pkg::FebMonth, cwrg_pkg::LeapFebLen);
            1: load_settings(3'd6, 15'd1752, cwrg_pkg::TransMonth, 5'd14);
            2: load_settings(3'd7, 15'd32767, cwrg_pkg::LastMonth, 5'd31);
            3: load_settings(3'd3, 15'd1752, cwrg_pkg::TransMonth, 5'd2);
            4: load_settings(3'd5, 15'd0, 4'd15, 5'd0);
            default: load_settings(3'($urandom_range(7)), 15'($urandom_range(2400, 1600)),
                                   4'($urandom_range(11)), 5'($urandom_range(31, 1)));
         endcase
         set_pace(pace_mode_type'(p % 4));
         for (int i = 0; i < 60; i++) begin
            // let the pipeline run dry once per phase
            if (i == 30) wait_drained();
            send_random_row();
         end
         wait_drained();
      end

      set_pace(PACE_FREE);
      repeat (20) @(posedge clock);
      $display("%0d row requests (%0d directed) over %0d register settings, four pacing modes",
               rows_sent, directed_rows, settings_used);
      $display("%0d cells compared, %0d of them highlighted", cells_checked,
               highlights_checked);
      if (fail_count == 0 && cells_due == 0) begin
         $display("calendar_week_row_generator_tb passed");
      end else begin
         $display("calendar_week_row_generator_tb failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d cells still due", cells_due);
      $display("calendar_week_row_generator_tb failed");
      $finish;
   end

endmodule
